### rtl/core/u8ld_pkg.sv
package u8ld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 31;
  localparam int unsigned LenW  = 3;
  localparam int unsigned NumCont = 4;

  localparam logic [LenW-1:0] LenOne = 3'd1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EMIT_SEQ,
    OP_STORE_CONT,
    OP_OPEN,
    OP_EMIT_RAW,
    OP_FLUSH_EMIT
  } op_t;

  typedef struct packed {
    logic sel_in;
    logic cap;
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic is_cont;
    logic complete;
    logic cur_single;
    logic cur_fin;
    logic elem_last;
    logic byte_lead;
    logic fin_held;
    logic out_free;
  } status_t;

  function automatic logic [LenW-1:0] seq_len(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    if (b inside {[8'hFC:8'hFD]}) len = 3'd6;
    else if (b inside {[8'hF8:8'hFB]}) len = 3'd5;
    else if (b inside {[8'hF0:8'hF4]}) len = 3'd4;
    else if (b inside {[8'hE0:8'hEF]}) len = 3'd3;
    else if (b inside {[8'hC0:8'hDF]}) len = 3'd2;
    else len = 3'd1;
    return len;
  endfunction

endpackage

### rtl/core/u8ld_datapath.sv
module u8ld_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  u8ld_pkg::cmd_t               cmd,
  output u8ld_pkg::status_t            st,
  input  logic [7:0]                   in_text_byte,
  input  logic                         in_final_byte,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [30:0]                  out_code_point,
  output logic [2:0]                   out_byte_length,
  output logic                         out_last_of_run
);
  import u8ld_pkg::*;

  logic [ByteW-1:0] lead_r, lead_nxt;
  logic [LenW-1:0]  exp_r, exp_nxt;
  logic [LenW-1:0]  rc_r, rc_nxt;
  logic [CodeW-1:0] partial_r, partial_nxt;
  logic [LenW-1:0]  idx_r, idx_nxt;
  logic [ByteW-1:0] byte_r;
  logic             fin_r;
  logic [ByteW-1:0] cont_r [NumCont];
  logic             out_valid_r, out_valid_nxt;
  logic [CodeW-1:0] out_cp_r;
  logic [LenW-1:0]  out_len_r;
  logic             out_last_r;

  logic [ByteW-1:0] cur_byte;
  logic             cur_fin;
  logic [LenW-1:0]  cur_len;
  logic [CodeW-1:0] shifted;
  logic [1:0]       wr_idx;
  logic [ByteW-1:0] elem;
  logic [ByteW-1:0] lead_mask;
  logic             emit;
  logic [CodeW-1:0] emit_cp;
  logic [LenW-1:0]  emit_len;

  always_comb begin
    cur_byte  = cmd.sel_in ? in_text_byte : byte_r;
    cur_fin   = cmd.sel_in ? in_final_byte : fin_r;
    cur_len   = seq_len(cur_byte);
    shifted   = {partial_r[CodeW-7:0], cur_byte[5:0]};
    wr_idx    = rc_r[1:0] - 2'd1;
    elem      = (idx_r == 3'd0) ? lead_r : cont_r[idx_r[1:0] - 2'd1];
    lead_mask = 8'h7F >> cur_len;

    st.pending    = (exp_r != 3'd0);
    st.is_cont    = (cur_byte inside {[8'h80:8'hBF]});
    st.complete   = ({1'b0, rc_r} + 4'd1) >= {1'b0, exp_r};
    st.cur_single = (cur_len == LenOne);
    st.cur_fin    = cur_fin;
    st.elem_last  = (idx_r == (rc_r - 3'd1));
    st.byte_lead  = (seq_len(byte_r) != LenOne);
    st.fin_held   = fin_r;
    st.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    lead_nxt    = lead_r;
    exp_nxt     = exp_r;
    rc_nxt      = rc_r;
    partial_nxt = partial_r;
    idx_nxt     = idx_r;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_len    = LenOne;
    case (cmd.op)
      OP_EMIT_SEQ: begin
        emit        = 1'b1;
        emit_cp     = shifted;
        emit_len    = exp_r;
        lead_nxt    = '0;
        exp_nxt     = '0;
        rc_nxt      = '0;
        partial_nxt = '0;
      end
      OP_STORE_CONT: begin
        partial_nxt = shifted;
        rc_nxt      = rc_r + 3'd1;
      end
      OP_OPEN: begin
        lead_nxt    = cur_byte;
        exp_nxt     = cur_len;
        rc_nxt      = 3'd1;
        partial_nxt = {23'd0, cur_byte & lead_mask};
      end
      OP_EMIT_RAW: begin
        emit    = 1'b1;
        emit_cp = {23'd0, cur_byte};
      end
      OP_FLUSH_EMIT: begin
        emit    = 1'b1;
        emit_cp = {23'd0, elem};
        if (st.elem_last) begin
          idx_nxt     = '0;
          lead_nxt    = '0;
          exp_nxt     = '0;
          rc_nxt      = '0;
          partial_nxt = '0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r      <= '0;
      exp_r       <= '0;
      rc_r        <= '0;
      partial_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lead_r      <= lead_nxt;
      exp_r       <= exp_nxt;
      rc_r        <= rc_nxt;
      partial_r   <= partial_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      byte_r <= in_text_byte;
      fin_r  <= in_final_byte;
    end
    if (cmd.op == OP_STORE_CONT) begin
      cont_r[wr_idx] <= cur_byte;
    end
    if (emit) begin
      out_cp_r   <= emit_cp;
      out_len_r  <= emit_len;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = out_cp_r;
  assign out_byte_length = out_len_r;
  assign out_last_of_run = out_last_r;

endmodule

### rtl/core/u8ld_ctrl.sv
module u8ld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  u8ld_pkg::status_t st,
  output u8ld_pkg::cmd_t    cmd
);
  import u8ld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   after_idle_r, after_idle_nxt;
  logic   go;

  always_comb begin
    state_nxt      = state_r;
    after_idle_nxt = after_idle_r;
    cmd.sel_in     = (state_r == S_IDLE);
    cmd.cap        = 1'b0;
    cmd.op         = OP_NONE;
    cmd.last       = 1'b1;
    in_stall       = !((state_r == S_IDLE) && st.out_free);
    go             = 1'b0;
    case (state_r)
      S_IDLE: begin
        go      = in_valid && st.out_free;
        cmd.cap = go;
      end
      S_EVAL: begin
        go = st.out_free;
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.op   = OP_FLUSH_EMIT;
          cmd.last = st.elem_last && (after_idle_r || (st.byte_lead && !st.fin_held));
          if (st.elem_last) begin
            state_nxt = after_idle_r ? S_IDLE : S_EVAL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go) begin
      state_nxt = S_IDLE;
      if (st.pending && st.is_cont) begin
        if (st.complete) begin
          cmd.op = OP_EMIT_SEQ;
        end else begin
          cmd.op = OP_STORE_CONT;
          if (st.cur_fin) begin
            state_nxt      = S_FLUSH;
            after_idle_nxt = 1'b1;
          end
        end
      end else if (st.pending) begin
        state_nxt      = S_FLUSH;
        after_idle_nxt = 1'b0;
      end else if (st.cur_single) begin
        cmd.op = OP_EMIT_RAW;
      end else begin
        cmd.op = OP_OPEN;
        if (st.cur_fin) begin
          state_nxt      = S_FLUSH;
          after_idle_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      after_idle_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      after_idle_r <= after_idle_nxt;
    end
  end

endmodule

### rtl/core/utf8_lenient_decoder_top.sv
// A result is registered: it shows in the cycle after the beat that completes it.
// Throughput: one beat per cycle while bytes decode cleanly and out_stall is low.
// A broken or flushed sequence replays its buffered bytes at one result per cycle
// if not stalled, via the single output register; a breaking byte is re-evaluated.
// Reset (rst_n low, synchronous) clears the pending sequence and the output valid.
module utf8_lenient_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_code_point,
  output logic [2:0]  out_byte_length,
  output logic        out_last_of_run
);
  import u8ld_pkg::*;

  cmd_t    cmd;
  status_t st;

  u8ld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  u8ld_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_text_byte    (in_text_byte),
    .in_final_byte   (in_final_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_code_point  (out_code_point),
    .out_byte_length (out_byte_length),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### rtl/core/u8ld_checker.sv
module u8ld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_text_byte,
  input logic        in_final_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_code_point,
  input logic [2:0]  out_byte_length,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_byte_length) && $stable(out_last_of_run))
    else $error("stalled result beat changed");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_length != 3'd0 && out_byte_length != 3'd7)
    else $error("result length out of range");

  a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_length == 3'd1 |-> out_code_point[30:8] == 23'd0)
    else $error("raw result wider than a byte");

  a_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_length == 3'd2 |-> out_code_point[30:11] == 20'd0)
    else $error("two-byte result wider than eleven bits");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input beat taken while output register is blocked");

endmodule

bind utf8_lenient_decoder_top u8ld_checker u_chk (.*);
